// ===== rtl/three_phase_microstep_sequencer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the three-phase microstep sequencer
// Clocked on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef THREE_PHASE_MICROSTEP_SEQUENCER_MACROS_SVH
`define THREE_PHASE_MICROSTEP_SEQUENCER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication
`define TPMS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tpms assertion failed");

// Next-cycle implication
`define TPMS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tpms assertion failed");

`else

`define TPMS_ASSERT_IMP(lbl, ante, cons)
`define TPMS_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== rtl/tpms_pkg.sv =====
// ----------------------------------------------------------------------------
// tpms_pkg
// Types and constants shared by the microstep sequencer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package tpms_pkg;

	localparam int LEVEL_BITS = 8;
	localparam int MAX_STEPS  = 64;
	localparam int STEP_BITS  = 7;
	localparam int WINDINGS   = 3;
	localparam int WIDX_BITS  = $clog2(WINDINGS);
	localparam int PIN_BITS   = 8;
	localparam int OP_BITS    = 2;

	typedef logic [LEVEL_BITS-1:0] level_t;
	typedef logic [WIDX_BITS-1:0]  widx_t;
	typedef logic [STEP_BITS-1:0]  steps_t;
	typedef logic [PIN_BITS-1:0]   pin_t;
	typedef level_t [WINDINGS-1:0] level_vec_t;

	localparam level_t LEVEL_TOP = {LEVEL_BITS{1'b1}};
	localparam steps_t STEP_MAX  = STEP_BITS'(MAX_STEPS);

	localparam widx_t WIDX_A = WIDX_BITS'(0);
	localparam widx_t WIDX_B = WIDX_BITS'(1);
	localparam widx_t WIDX_C = WIDX_BITS'(2);

	typedef enum logic [OP_BITS-1:0] {
		OP_LOAD       = 2'd0,
		OP_STEP_RIGHT = 2'd1,
		OP_STEP_LEFT  = 2'd2,
		OP_NONE       = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_PIN_A = 2'd0,
		CFG_PIN_B = 2'd1,
		CFG_PIN_C = 2'd2,
		CFG_NONE  = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_STEP
	} state_t;

	typedef struct packed {
		logic [OP_BITS-1:0] operation;
		steps_t             step_count;
		level_t             level_a;
		level_t             level_b;
		level_t             level_c;
	} in_word_t;

	typedef struct packed {
		pin_t   pin_number;
		level_t pin_level;
		logic   last;
	} out_word_t;

	// result of one microstep: which winding moves and its new level
	typedef struct packed {
		widx_t  widx;
		level_t level;
	} step_res_t;

endpackage

`default_nettype wire

// ===== rtl/tpms_step_unit.sv =====
// ----------------------------------------------------------------------------
// tpms_step_unit
// Compare and increment/decrement unit shared by every microstep.
// ----------------------------------------------------------------------------
`default_nettype none

module tpms_step_unit import tpms_pkg::*; (
	input  level_vec_t levels,
	input  logic       left,
	output step_res_t  res
);

	widx_t  j, i, k, ir, kr, w;
	level_t lj, li, lk, lw;
	logic   up;

	always_comb begin
		// highest winding, lowest index wins a tie
		j = WIDX_A;
		if (levels[WIDX_B] > levels[WIDX_A]) begin
			j = WIDX_B;
		end
		if (levels[WIDX_C] > levels[j]) begin
			j = WIDX_C;
		end

		unique case (j)
			WIDX_A: begin
				ir = WIDX_C;
				kr = WIDX_B;
			end
			WIDX_B: begin
				ir = WIDX_A;
				kr = WIDX_C;
			end
			default: begin
				ir = WIDX_B;
				kr = WIDX_A;
			end
		endcase

		// swap neighbors when stepping left
		i = left ? kr : ir;
		k = left ? ir : kr;

		lj = levels[j];
		li = levels[i];
		lk = levels[k];

		priority if (li > lk) begin
			w  = i;
			up = 1'b0;
		end else if (li == lk) begin
			w  = k;
			up = 1'b1;
		end else if (lk == lj) begin
			w  = j;
			up = 1'b0;
		end else begin
			w  = k;
			up = 1'b1;
		end

		lw = levels[w];
		res.widx = w;
		if (up) begin
			res.level = (lw == LEVEL_TOP) ? lw : lw + 1'b1;
		end else begin
			res.level = (lw == '0) ? lw : lw - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/three_phase_microstep_sequencer.sv =====
// ----------------------------------------------------------------------------
// three_phase_microstep_sequencer
// Drive-level sequencer for a three-winding reluctance motor.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data take one command word: a load of all three
//   winding levels, or a right/left run of step_count microsteps (capped at
//   64). Operation three and a zero count are dropped. out_valid/out_stall/
//   out_data give one pin write word per loaded winding or microstep, with
//   last on the final word. cfg_we/cfg_index/cfg_data set each winding's pin
//   number; write only while idle.
// Timing:
//   After a command is taken, one word is produced per cycle unless out_stall
//   holds the output register; step words come from the shared compare/increment
//   unit, load words from the level registers. The first word reaches out_valid
//   via the state register and the output register. in_stall is high while it runs.
// Reset: arst_n clears all levels to zero, pins to 0/1/2, the sequencer to idle.
// Stall: while out_stall holds a word in the output register, a running command
//   holds its state; no word is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

`include "three_phase_microstep_sequencer_macros.svh"

module three_phase_microstep_sequencer import tpms_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_word_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_word_t out_data,
	input  logic      cfg_we,
	input  cfg_idx_t  cfg_index,
	input  pin_t      cfg_data
);

	state_t     state_q, state_d;
	level_vec_t lvl_q;
	pin_t       pin_q [WINDINGS];
	steps_t     steps_q;
	logic       left_q;
	widx_t      widx_q;
	logic       out_valid_q;
	out_word_t  out_data_q;

	logic       in_fire;
	logic       emit;
	op_t        op;
	steps_t     cnt_sat;
	step_res_t  step_res;
	out_word_t  out_d;

	tpms_step_unit u_step (
		.levels (lvl_q),
		.left   (left_q),
		.res    (step_res)
	);

	assign op      = op_t'(in_data.operation);
	assign cnt_sat = (in_data.step_count > STEP_MAX) ? STEP_MAX : in_data.step_count;
	assign in_fire = in_valid && !in_stall;
	// advance only when the output register is free or being drained
	assign emit    = (state_q != ST_IDLE) && (!out_valid_q || !out_stall);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (op == OP_LOAD) begin
						state_d = ST_LOAD;
					end else if ((op == OP_STEP_RIGHT || op == OP_STEP_LEFT) &&
						cnt_sat != '0) begin
						state_d = ST_STEP;
					end
				end
			end
			ST_LOAD: begin
				if (emit && widx_q == WIDX_C) begin
					state_d = ST_IDLE;
				end
			end
			ST_STEP: begin
				if (emit && steps_q == STEP_BITS'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs: handshake and the next result word
	always_comb begin
		in_stall = (state_q != ST_IDLE);
		out_d    = '0;
		unique case (state_q)
			ST_LOAD: begin
				out_d.pin_number = pin_q[widx_q];
				out_d.pin_level  = lvl_q[widx_q];
				out_d.last       = (widx_q == WIDX_C);
			end
			ST_STEP: begin
				out_d.pin_number = pin_q[step_res.widx];
				out_d.pin_level  = step_res.level;
				out_d.last       = (steps_q == STEP_BITS'(1));
			end
			default: out_d = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lvl_q       <= '0;
			pin_q[0]    <= PIN_BITS'(0);
			pin_q[1]    <= PIN_BITS'(1);
			pin_q[2]    <= PIN_BITS'(2);
			steps_q     <= '0;
			left_q      <= 1'b0;
			widx_q      <= WIDX_A;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// pin registers
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_PIN_A: pin_q[0] <= cfg_data;
					CFG_PIN_B: pin_q[1] <= cfg_data;
					CFG_PIN_C: pin_q[2] <= cfg_data;
					default: ;
				endcase
			end

			// take a command
			if (in_fire) begin
				if (op == OP_LOAD) begin
					lvl_q[WIDX_A] <= in_data.level_a;
					lvl_q[WIDX_B] <= in_data.level_b;
					lvl_q[WIDX_C] <= in_data.level_c;
					widx_q        <= WIDX_A;
				end else if (op == OP_STEP_RIGHT || op == OP_STEP_LEFT) begin
					left_q  <= (op == OP_STEP_LEFT);
					steps_q <= cnt_sat;
				end
			end

			// run one word of the command
			if (emit) begin
				if (state_q == ST_LOAD) begin
					widx_q <= widx_q + 1'b1;
				end else begin
					lvl_q[step_res.widx] <= step_res.level;
					steps_q              <= steps_q - 1'b1;
				end
			end

			// output register: load on emit, drop when taken
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= out_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// steps left only inside a step run
	`TPMS_ASSERT_IMP(a_steps_idle, steps_q != '0, state_q == ST_STEP)
	// the last word closes the command
	`TPMS_ASSERT_NXT(a_last_idle, emit && out_d.last, state_q == ST_IDLE)
	// load index stays on a winding
	`TPMS_ASSERT_IMP(a_load_idx, state_q == ST_LOAD, widx_q <= WIDX_C)
	// no word moves while the output register is stalled
	`TPMS_ASSERT_IMP(a_hold_on_stall, out_valid_q && out_stall, !emit)

endmodule

`default_nettype wire

// ===== test/pin_write_checker.sv =====
// ----------------------------------------------------------------------------
// pin_write_checker
// Watches the command, pin write and register channels of the microstep
// sequencer, keeps its own copy of the winding levels and pin numbers,
// predicts every pin write word and compares each one, field by field,
// with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module pin_write_checker import tpms_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  in_word_t    in_data,
	input  logic        out_valid,
	input  logic        out_stall,
	input  out_word_t   out_data,
	input  logic        cfg_we,
	input  cfg_idx_t    cfg_index,
	input  pin_t        cfg_data,
	output int unsigned fail_count,
	output int unsigned pending_writes
);

	level_t      level_now [WINDINGS];
	pin_t        pin_now [WINDINGS];
	out_word_t   pin_writes_due [$];
	int unsigned mismatches;

	task automatic nudge(input int w, input bit up);
		if (up) begin
			if (level_now[w] != LEVEL_TOP)
				level_now[w] = level_now[w] + 1'b1;
		end else if (level_now[w] != '0) begin
			level_now[w] = level_now[w] - 1'b1;
		end
	endtask

	// one microstep: move the winding chosen by comparing the neighbours of
	// the highest one (lowest index wins a tie for highest)
	task automatic microstep(input bit left, output int moved);
		int hi, trail, lead, t;
		hi = 0;
		for (t = 1; t < WINDINGS; t++)
			if (level_now[t] > level_now[hi])
				hi = t;
		trail = (hi + 2) % WINDINGS;
		lead  = (hi + 1) % WINDINGS;
		if (left) begin
			t     = trail;
			trail = lead;
			lead  = t;
		end
		if (level_now[trail] > level_now[lead]) begin
			moved = trail;
			nudge(trail, 1'b0);
		end else if (level_now[trail] == level_now[lead]) begin
			moved = lead;
			nudge(lead, 1'b1);
		end else if (level_now[lead] == level_now[hi]) begin
			moved = hi;
			nudge(hi, 1'b0);
		end else begin
			moved = lead;
			nudge(lead, 1'b1);
		end
	endtask

	task automatic queue_write(input int w, input bit fin);
		out_word_t r;
		r.pin_number = pin_now[w];
		r.pin_level  = level_now[w];
		r.last       = fin;
		pin_writes_due.push_back(r);
	endtask

	task automatic predict(input in_word_t w);
		int n, t, moved;
		if (w.operation == OP_LOAD) begin
			level_now[0] = w.level_a;
			level_now[1] = w.level_b;
			level_now[2] = w.level_c;
			for (t = 0; t < WINDINGS; t++)
				queue_write(t, t == WINDINGS - 1);
		end else if (w.operation != OP_NONE) begin
			n = int'(w.step_count);
			if (n > MAX_STEPS)
				n = MAX_STEPS;
			for (t = n; t > 0; t--) begin
				microstep(w.operation == OP_STEP_LEFT, moved);
				queue_write(moved, t == 1);
			end
		end
	endtask

	task automatic check_word(input out_word_t got);
		out_word_t want;
		if (pin_writes_due.size() == 0) begin
			$display("%0t: unexpected word: expected none, got pin %0d level %0d last %0d",
				$time, got.pin_number, got.pin_level, got.last);
			mismatches++;
			return;
		end
		want = pin_writes_due.pop_front();
		if (got.pin_number != want.pin_number) begin
			$display("%0t: pin_number: expected %0d, got %0d",
				$time, want.pin_number, got.pin_number);
			mismatches++;
		end
		if (got.pin_level != want.pin_level) begin
			$display("%0t: pin_level: expected %0d, got %0d",
				$time, want.pin_level, got.pin_level);
			mismatches++;
		end
		if (got.last != want.last) begin
			$display("%0t: last: expected %0d, got %0d", $time, want.last, got.last);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < WINDINGS; t++) begin
				level_now[t] = '0;
				pin_now[t]   = pin_t'(t);
			end
			pin_writes_due.delete();
			mismatches = 0;
			fail_count     <= 0;
			pending_writes <= 0;
		end else begin
			// words leaving now were predicted earlier, so check before predicting
			if (out_valid && !out_stall)
				check_word(out_data);
			if (cfg_we && cfg_index != CFG_NONE)
				pin_now[cfg_index] = cfg_data;
			if (in_valid && !in_stall)
				predict(in_data);
			fail_count     <= mismatches;
			pending_writes <= pin_writes_due.size();
		end
	end

endmodule

// ===== test/tb_three_phase_microstep_sequencer.sv =====
// ----------------------------------------------------------------------------
// tb_three_phase_microstep_sequencer
// Drives load, step and dropped commands into the sequencer under random
// gaps and output stalls, changes the winding pin numbers between phases,
// and lets pin_write_checker compare every pin write word.
// ----------------------------------------------------------------------------
module tb_three_phase_microstep_sequencer;
	import tpms_pkg::*;

	localparam int CLK_HALF        = 4;
	localparam int RESET_CYCLES    = 7;
	localparam int SETTLE_CYCLES   = 10;   // first word shows after the state and output registers
	localparam int IDLE_LIMIT      = 2000; // well above the longest hold-off
	localparam int HOLD_CYCLES     = 300;
	localparam int WORDS_PER_PHASE = 22;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	in_word_t    in_data;
	logic        out_valid;
	logic        out_stall;
	out_word_t   out_data;
	logic        cfg_we;
	cfg_idx_t    cfg_index;
	pin_t        cfg_data;
	int unsigned fail_count;
	int unsigned pending_writes;

	// calm: no gaps on either side; squeeze: ask the receiver for one long hold
	bit calm;
	bit squeeze;

	three_phase_microstep_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	pin_write_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.fail_count     (fail_count),
		.pending_writes (pending_writes)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Gap length for either side: mostly none or short, now and then long.
	function automatic int pick_gap();
		int roll;
		if (calm)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 45)
			return 0;
		if (roll < 80)
			return $urandom_range(1, 3);
		if (roll < 96)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic in_word_t make_word(op_t op, int n, int a, int b, int c);
		in_word_t w;
		w.operation  = op;
		w.step_count = steps_t'(n);
		w.level_a    = level_t'(a);
		w.level_b    = level_t'(b);
		w.level_c    = level_t'(c);
		return w;
	endfunction

	// Lean on the rails and on small values, where saturation and ties live.
	function automatic level_t rand_level();
		case ($urandom_range(0, 5))
			0: begin
				return '0;
			end
			1: begin
				return LEVEL_TOP;
			end
			2: begin
				return level_t'($urandom_range(250, 255));
			end
			3: begin
				return level_t'($urandom_range(0, 5));
			end
			default: begin
				return level_t'($urandom_range(0, 255));
			end
		endcase
	endfunction

	// Short runs mostly; some longer ones up to full length, a few past the cap and a few of zero.
	function automatic steps_t rand_count();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return steps_t'($urandom_range(1, 6));
		if (roll < 85)
			return steps_t'($urandom_range(7, 64));
		if (roll < 95)
			return steps_t'($urandom_range(65, 127));
		return '0;
	endfunction

	// Mostly step runs, with some loads and a few dropped commands; every field
	// gets random content even where the operation ignores it.
	function automatic in_word_t random_cmd();
		in_word_t w;
		int roll;
		w.step_count = steps_t'($urandom);
		w.level_a    = rand_level();
		w.level_b    = rand_level();
		w.level_c    = rand_level();
		roll = $urandom_range(0, 99);
		if (roll < 25) begin
			w.operation = OP_LOAD;
			if ($urandom_range(0, 3) == 0)
				w.level_b = w.level_a;
			if ($urandom_range(0, 3) == 0)
				w.level_c = $urandom_range(0, 1) ? w.level_a : w.level_b;
		end else if (roll < 95) begin
			w.operation  = $urandom_range(0, 1) ? OP_STEP_RIGHT : OP_STEP_LEFT;
			w.step_count = rand_count();
		end else begin
			w.operation = OP_NONE;
		end
		return w;
	endfunction

	// Offer one command word and hold it until the block takes it. Valid is
	// only lowered when a gap is wanted, so back-to-back words keep it high.
	task automatic send_cmd(input in_word_t w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		do @(posedge clk); while (in_stall);
	endtask

	// Drop valid and wait for every predicted word, then let the block go
	// idle; dropped commands leave nothing to wait for, hence the tail.
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_writes != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input pin_t d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		@(posedge clk);
	endtask

	task automatic set_pins(input pin_t a, input pin_t b, input pin_t c);
		write_reg(CFG_PIN_A, a);
		write_reg(CFG_PIN_B, b);
		write_reg(CFG_PIN_C, c);
		cfg_we <= 1'b0;
	endtask

	// Receiver: random stall bursts between short open windows, and one long
	// hold when asked so the block backs up and stalls the command channel.
	initial begin
		int stall_len;
		int open_len;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall_len = pick_gap();
			open_len  = $urandom_range(1, 8);
			if (squeeze) begin
				stall_len = HOLD_CYCLES;
				squeeze   = 1'b0;
			end
			if (stall_len > 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(posedge clk);
			end
			out_stall <= 1'b0;
			repeat (open_len) @(posedge clk);
		end
	end

	// Watchdog: end the run once nothing has moved on either channel for
	// too long.
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		wait (arst_n === 1'b1);
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int k;
		in_valid  <= 1'b0;
		in_data   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= CFG_PIN_A;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		calm      = 1'b0;
		squeeze   = 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, pins still at their reset numbers.
		// all windings at zero: three-way tie for highest
		send_cmd(make_word(OP_STEP_RIGHT, 1, 0, 0, 0));
		send_cmd(make_word(OP_STEP_LEFT, 1, 0, 0, 0));
		// all at the top: increments saturate but still write the pin
		send_cmd(make_word(OP_LOAD, 0, 255, 255, 255));
		send_cmd(make_word(OP_STEP_RIGHT, 3, 0, 0, 0));
		send_cmd(make_word(OP_STEP_LEFT, 2, 0, 0, 0));
		// zero count: nothing comes out, levels hold
		send_cmd(make_word(OP_LOAD, 127, 0, 0, 0));
		send_cmd(make_word(OP_STEP_RIGHT, 0, 255, 255, 255));
		// full-length runs in both directions
		send_cmd(make_word(OP_LOAD, 0, 10, 20, 30));
		send_cmd(make_word(OP_STEP_RIGHT, 64, 0, 0, 0));
		send_cmd(make_word(OP_STEP_LEFT, 64, 0, 0, 0));
		// counts past the cap run only the capped number of microsteps
		send_cmd(make_word(OP_LOAD, 0, 200, 100, 50));
		send_cmd(make_word(OP_STEP_LEFT, 127, 0, 0, 0));
		send_cmd(make_word(OP_STEP_RIGHT, 65, 0, 0, 0));
		// operation three is dropped whatever its fields hold
		send_cmd(make_word(OP_NONE, 127, 255, 255, 255));
		// ties for highest in every position
		send_cmd(make_word(OP_LOAD, 0, 7, 7, 3));
		send_cmd(make_word(OP_STEP_RIGHT, 4, 0, 0, 0));
		send_cmd(make_word(OP_LOAD, 0, 3, 7, 7));
		send_cmd(make_word(OP_STEP_LEFT, 4, 0, 0, 0));
		send_cmd(make_word(OP_LOAD, 0, 7, 3, 7));
		send_cmd(make_word(OP_STEP_RIGHT, 6, 0, 0, 0));
		// spread levels, then walk each way
		send_cmd(make_word(OP_LOAD, 0, 255, 0, 128));
		send_cmd(make_word(OP_STEP_LEFT, 5, 0, 0, 0));
		send_cmd(make_word(OP_STEP_RIGHT, 5, 0, 0, 0));
		send_cmd(make_word(OP_NONE, 0, 0, 0, 0));
		settle();

		// Random phase with pins at the low and high extremes.
		set_pins(8'h00, 8'hFF, pin_t'($urandom));
		for (k = 0; k < WORDS_PER_PHASE; k++)
			send_cmd(random_cmd());
		settle();

		// Random phase under one long receiver hold; the spare register
		// index is written too and must change nothing.
		write_reg(CFG_NONE, pin_t'($urandom));
		set_pins(8'hFF, 8'h00, pin_t'($urandom));
		squeeze = 1'b1;
		for (k = 0; k < WORDS_PER_PHASE; k++)
			send_cmd(random_cmd());
		settle();

		// Random pins, random phase.
		set_pins(pin_t'($urandom), pin_t'($urandom), pin_t'($urandom));
		for (k = 0; k < WORDS_PER_PHASE; k++)
			send_cmd(random_cmd());
		settle();

		// Full-rate phase: no gaps and no stalls, all pins at the top.
		set_pins(8'hFF, 8'hFF, 8'hFF);
		calm = 1'b1;
		for (k = 0; k < WORDS_PER_PHASE; k++)
			send_cmd(random_cmd());
		settle();

		if (fail_count == 0 && pending_writes == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
